[rtl/zero_sum_triple_finder_macros.svh]
// assertion helpers for the triple finder
`ifndef ZERO_SUM_TRIPLE_FINDER_MACROS_SVH
`define ZERO_SUM_TRIPLE_FINDER_MACROS_SVH

// implication checked every clock outside reset
`define ZSTF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define ZSTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/zstf_pkg.sv]
package zstf_pkg;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_FETCH = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] ST_LOADED    = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_CLEARED   = 3'd4;

  // pair sum against negated anchor
  localparam logic [1:0] CMP_EQ = 2'd0;
  localparam logic [1:0] CMP_LT = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] first;
    logic signed [31:0] second;
    logic signed [31:0] third;
  } out_word_t;

  // datapath commands
  localparam logic [3:0] DC_NOP      = 4'd0;
  localparam logic [3:0] DC_LOAD     = 4'd1;
  localparam logic [3:0] DC_CLEAR    = 4'd2;
  localparam logic [3:0] DC_RD_A     = 4'd3;  // read store at a
  localparam logic [3:0] DC_RD_B     = 4'd4;  // read store at b
  localparam logic [3:0] DC_WR_B     = 4'd5;  // write key at b
  localparam logic [3:0] DC_WR_SHIFT = 4'd6;  // write held word at b
  localparam logic [3:0] DC_SET_A    = 4'd7;  // a <= b (general)
  localparam logic [3:0] DC_SRCH_INIT = 4'd8;
  localparam logic [3:0] DC_AN_INIT  = 4'd9;
  localparam logic [3:0] DC_RD_LO    = 4'd10;
  localparam logic [3:0] DC_RD_HI    = 4'd11;

  typedef struct packed {
    logic [3:0] cmd;
  } dp_cmd_t;

endpackage

[rtl/zstf_ram.sv]
module zstf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/zstf_datapath.sv]
module zstf_datapath import zstf_pkg::*; #(
  parameter int AW = 6,
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic signed [31:0]  wdata,
  input  logic [AW-1:0]       raddr,
  output logic signed [31:0]  rdata,
  input  logic signed [31:0]  anchor_v,
  input  logic signed [31:0]  lo_v,
  input  logic signed [31:0]  hi_v,
  output logic [1:0]          cmp  // equal, less or greater
);

  logic [31:0] rd_raw;
  logic signed [33:0] sum_w;
  logic signed [33:0] tgt_w;

  zstf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rd_raw)
  );

  assign rdata = $signed(rd_raw);

  // wide pair sum against negated anchor
  assign sum_w = 34'(lo_v) + 34'(hi_v);
  assign tgt_w = -34'(anchor_v);
  assign cmp = (sum_w == tgt_w) ? CMP_EQ : ((sum_w < tgt_w) ? CMP_LT : CMP_GT);

endmodule

[rtl/zstf_ctrl.sv]
module zstf_ctrl import zstf_pkg::*; #(
  parameter int AW = 6,
  parameter int CW = 7,
  parameter int MAXN = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  in_word_t           in_word,
  output logic               busy,
  output logic               out_strobe,
  output out_word_t          out_word,
  output logic               we,
  output logic [AW-1:0]      waddr,
  output logic signed [31:0] wdata,
  output logic [AW-1:0]      raddr,
  input  logic signed [31:0] rdata,
  output logic signed [31:0] anchor_v,
  output logic signed [31:0] lo_v,
  output logic signed [31:0] hi_v,
  input  logic [1:0]         cmp
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_SI_RD  = 5'd1;   // sort: read key at i
  localparam logic [4:0] S_SI_KEY = 5'd2;
  localparam logic [4:0] S_SJ_RD  = 5'd3;   // read j-1
  localparam logic [4:0] S_SJ_CMP = 5'd4;
  localparam logic [4:0] S_A_RD   = 5'd5;   // read anchor
  localparam logic [4:0] S_A_W    = 5'd6;
  localparam logic [4:0] S_P_RD   = 5'd7;   // read low
  localparam logic [4:0] S_P_RH   = 5'd8;   // latch low, read high
  localparam logic [4:0] S_P_HW   = 5'd9;   // latch high
  localparam logic [4:0] S_P_CMP  = 5'd10;
  localparam logic [4:0] S_DL_RD  = 5'd11;  // dup skip low
  localparam logic [4:0] S_DL_W   = 5'd12;
  localparam logic [4:0] S_DH_RD  = 5'd13;
  localparam logic [4:0] S_DH_W   = 5'd14;
  localparam logic [4:0] S_AN_RD  = 5'd15;  // anchor dup skip
  localparam logic [4:0] S_AN_W   = 5'd16;
  localparam logic [4:0] S_FIN    = 5'd17;
  localparam logic [4:0] S_DL_LAT = 5'd18;
  localparam logic [4:0] S_DH_LAT = 5'd19;

  logic [4:0] state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic sorted_r, sorted_nxt, started_r, started_nxt;
  logic [CW-1:0] an_r, an_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic signed [31:0] key_r, key_nxt, av_r, av_nxt, lv_r, lv_nxt, hv_r, hv_nxt;
  logic signed [31:0] prev_r, prev_nxt;
  logic found_r, found_nxt;
  logic strobe_r, strobe_nxt;
  out_word_t res_r, res_nxt;

  assign busy = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_word = res_r;
  assign anchor_v = av_r;
  assign lo_v = lv_r;
  assign hi_v = hv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      sorted_r <= 1'b0;
      started_r <= 1'b0;
      an_r <= '0;
      lo_r <= '0;
      hi_r <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      sorted_r <= sorted_nxt;
      started_r <= started_nxt;
      an_r <= an_nxt;
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    key_r <= key_nxt;
    av_r <= av_nxt;
    lv_r <= lv_nxt;
    hv_r <= hv_nxt;
    prev_r <= prev_nxt;
    found_r <= found_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    sorted_nxt = sorted_r;
    started_nxt = started_r;
    an_nxt = an_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    i_nxt = i_r;
    j_nxt = j_r;
    key_nxt = key_r;
    av_nxt = av_r;
    lv_nxt = lv_r;
    hv_nxt = hv_r;
    prev_nxt = prev_r;
    found_nxt = found_r;
    res_nxt = res_r;
    strobe_nxt = 1'b0;
    we = 1'b0;
    waddr = '0;
    wdata = key_r;
    raddr = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          res_nxt = '0;
          unique case (in_word.opcode)
            OP_LOAD: begin
              strobe_nxt = 1'b1;
              if (cnt_r >= CW'(MAXN)) begin
                res_nxt.status = ST_FULL;
              end else begin
                we = 1'b1;
                waddr = cnt_r[AW-1:0];
                wdata = in_word.value;
                cnt_nxt = cnt_r + 1'b1;
                sorted_nxt = 1'b0;
                started_nxt = 1'b0;
                res_nxt.status = ST_LOADED;
              end
            end
            OP_CLEAR: begin
              strobe_nxt = 1'b1;
              cnt_nxt = '0;
              sorted_nxt = 1'b0;
              started_nxt = 1'b0;
              an_nxt = '0;
              lo_nxt = '0;
              hi_nxt = '0;
              res_nxt.status = ST_CLEARED;
            end
            OP_FETCH: begin
              found_nxt = 1'b0;
              if (!sorted_r) begin
                sorted_nxt = 1'b1;
                started_nxt = 1'b0;
                i_nxt = CW'(1);
                state_nxt = S_SI_RD;
              end else if (!started_r) begin
                an_nxt = '0;
                state_nxt = S_A_RD;
              end else begin
                state_nxt = S_A_RD;
              end
            end
            default: ;
          endcase
        end
      end
      // insertion sort, one compare per visit
      S_SI_RD: begin
        if (i_r >= cnt_r) begin
          an_nxt = '0;
          state_nxt = S_A_RD;
        end else begin
          raddr = i_r[AW-1:0];
          state_nxt = S_SI_KEY;
        end
      end
      S_SI_KEY: begin
        key_nxt = rdata;
        j_nxt = i_r;
        state_nxt = S_SJ_RD;
      end
      S_SJ_RD: begin
        if (j_r == '0) begin
          we = 1'b1;
          waddr = j_r[AW-1:0];
          wdata = key_r;
          i_nxt = i_r + 1'b1;
          state_nxt = S_SI_RD;
        end else begin
          raddr = AW'(j_r - 1'b1);
          state_nxt = S_SJ_CMP;
        end
      end
      S_SJ_CMP: begin
        we = 1'b1;
        waddr = j_r[AW-1:0];
        if (rdata > key_r) begin
          wdata = rdata;
          j_nxt = j_r - 1'b1;
          state_nxt = S_SJ_RD;
        end else begin
          wdata = key_r;
          i_nxt = i_r + 1'b1;
          state_nxt = S_SI_RD;
        end
      end
      // anchor entry; pointers placed when search starts fresh
      S_A_RD: begin
        if (!started_r) begin
          started_nxt = 1'b1;
          lo_nxt = an_r + 1'b1;
          hi_nxt = (cnt_r != '0) ? cnt_r - 1'b1 : '0;
        end
        if ((CW+1)'(an_r) + (CW+1)'(2) >= (CW+1)'(cnt_r)) begin
          state_nxt = S_FIN;
        end else begin
          raddr = an_r[AW-1:0];
          state_nxt = S_A_W;
        end
      end
      S_A_W: begin
        av_nxt = rdata;
        state_nxt = S_P_RD;
      end
      S_P_RD: begin
        if (lo_r < hi_r) begin
          raddr = lo_r[AW-1:0];
          state_nxt = S_P_RH;
        end else begin
          an_nxt = an_r + 1'b1;
          prev_nxt = av_r;
          state_nxt = S_AN_RD;
        end
      end
      S_P_RH: begin
        lv_nxt = rdata;
        raddr = hi_r[AW-1:0];
        state_nxt = S_P_HW;
      end
      S_P_HW: begin
        hv_nxt = rdata;
        state_nxt = S_P_CMP;
      end
      S_P_CMP: begin
        unique case (cmp)
          CMP_EQ: begin
            found_nxt = 1'b1;
            res_nxt.first = av_r;
            res_nxt.second = lv_r;
            res_nxt.third = hv_r;
            state_nxt = S_DL_RD;
          end
          CMP_LT: begin
            lo_nxt = lo_r + 1'b1;
            state_nxt = S_P_RD;
          end
          default: begin
            hi_nxt = hi_r - 1'b1;
            state_nxt = S_P_RD;
          end
        endcase
      end
      // skip equal lows; lv_r holds value at lo
      S_DL_RD: begin
        if (lo_r < hi_r) begin
          raddr = AW'(lo_r + 1'b1);
          state_nxt = S_DL_LAT;
        end else begin
          state_nxt = S_DH_RD;
        end
      end
      // hold the address so the word is still there next cycle
      S_DL_LAT: begin
        raddr = AW'(lo_r + 1'b1);
        state_nxt = S_DL_W;
      end
      S_DL_W: begin
        if (rdata == lv_r) begin
          lo_nxt = lo_r + 1'b1;
          state_nxt = S_DL_RD;
        end else begin
          state_nxt = S_DH_RD;
        end
      end
      S_DH_RD: begin
        if (lo_r < hi_r) begin
          raddr = AW'(hi_r - 1'b1);
          state_nxt = S_DH_LAT;
        end else begin
          lo_nxt = lo_r + 1'b1;
          hi_nxt = hi_r - 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_DH_LAT: begin
        raddr = AW'(hi_r - 1'b1);
        state_nxt = S_DH_W;
      end
      S_DH_W: begin
        if (rdata == hv_r) begin
          hi_nxt = hi_r - 1'b1;
          state_nxt = S_DH_RD;
        end else begin
          lo_nxt = lo_r + 1'b1;
          hi_nxt = hi_r - 1'b1;
          state_nxt = S_FIN;
        end
      end
      // skip anchors equal to the previous one
      S_AN_RD: begin
        if ((CW+1)'(an_r) + (CW+1)'(2) < (CW+1)'(cnt_r)) begin
          raddr = an_r[AW-1:0];
          state_nxt = S_AN_W;
        end else begin
          lo_nxt = an_r + 1'b1;
          hi_nxt = cnt_r - 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_AN_W: begin
        if (rdata == prev_r) begin
          an_nxt = an_r + 1'b1;
          state_nxt = S_AN_RD;
        end else begin
          av_nxt = rdata;
          lo_nxt = an_r + 1'b1;
          hi_nxt = cnt_r - 1'b1;
          state_nxt = S_P_RD;
        end
      end
      S_FIN: begin
        strobe_nxt = 1'b1;
        if (found_r) begin
          res_nxt.status = ST_FOUND;
        end else begin
          res_nxt = '0;
          res_nxt.status = ST_EXHAUSTED;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[rtl/zero_sum_triple_finder.sv]
// load and clear: word strobed in the cycle after start, one command accepted per cycle while not busy
// first fetch after a load sorts: each shifted entry takes a read state and a compare-and-write state
// fetch search: each pointer step reads low, latches low and reads high, latches high, then compares
// these step sequences follow from the single registered read port of the element store
// synchronous active-low reset empties the set; store contents stay undefined
// results come as one-cycle strobes, the receiver cannot stall
`include "zero_sum_triple_finder_macros.svh"
module zero_sum_triple_finder import zstf_pkg::*; #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_strobe,
  output out_word_t out_word
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic signed [31:0]  wdata, rdata, anchor_v, lo_v, hi_v;
  logic [1:0]          cmp;

  zstf_datapath #(.AW(AW), .DEPTH(MAX_ELEMENTS)) u_dp (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr),
    .rdata(rdata), .anchor_v(anchor_v), .lo_v(lo_v), .hi_v(hi_v), .cmp(cmp)
  );

  zstf_ctrl #(.AW(AW), .CW(CW), .MAXN(MAX_ELEMENTS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_word(in_word), .busy(busy),
    .out_strobe(out_strobe), .out_word(out_word), .we(we), .waddr(waddr),
    .wdata(wdata), .raddr(raddr), .rdata(rdata), .anchor_v(anchor_v),
    .lo_v(lo_v), .hi_v(hi_v), .cmp(cmp)
  );

  // checks
  `ZSTF_ASSERT_NEXT(a_load_ack, start && !busy && in_word.opcode == OP_LOAD,
    out_strobe, "load not acknowledged")
  `ZSTF_ASSERT_NEXT(a_clear_ack, start && !busy && in_word.opcode == OP_CLEAR,
    out_strobe && out_word.status == ST_CLEARED, "clear not acknowledged")
  `ZSTF_ASSERT_IMPL(a_zero_fields, out_strobe && out_word.status != ST_FOUND,
    out_word.first == 0 && out_word.third == 0, "fields nonzero without triple")

endmodule
